[rtl/core/sbm_pkg.sv]
// Shared types, opcode and status codes, and decode helpers for the bytecode stack machine.
// No dependencies; every other file in rtl/core imports this package.
package sbm_pkg;

    localparam int unsigned PC_W = 9;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] OP_PUSH  = 8'd0;
    localparam logic [7:0] OP_ADD   = 8'd1;
    localparam logic [7:0] OP_PRINT = 8'd2;
    localparam logic [7:0] OP_MUL   = 8'd3;
    localparam logic [7:0] OP_DIV   = 8'd4;
    localparam logic [7:0] OP_SUB   = 8'd5;
    localparam logic [7:0] OP_STORE = 8'd6;
    localparam logic [7:0] OP_LOAD  = 8'd7;
    localparam logic [7:0] OP_HALT  = 8'd8;
    localparam logic [7:0] OP_JMP   = 8'd9;
    localparam logic [7:0] OP_JZ    = 8'd10;
    localparam logic [7:0] OP_CALL  = 8'd11;

    localparam logic [2:0] STAT_RUN   = 3'd0;
    localparam logic [2:0] STAT_HALT  = 3'd1;
    localparam logic [2:0] STAT_UNDER = 3'd2;
    localparam logic [2:0] STAT_OVER  = 3'd3;
    localparam logic [2:0] STAT_DIVZ  = 3'd4;
    localparam logic [2:0] STAT_PAST  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_ARG,
        ST_EXEC,
        ST_WB,
        ST_DIV,
        ST_DONE
    } sbm_state_t;

    typedef struct packed {
        logic capture;
        logic latch_op;
        logic latch_arg;
        logic execute;
        logic write_back;
        logic finish;
    } sbm_cmd_t;

    typedef struct packed {
        logic start_exec;
        logic fault;
        logic arith;
        logic is_div;
        logic div_done;
        logic out_free;
    } sbm_sts_t;

    function automatic logic op_has_arg(input logic [7:0] op);
        return (op == OP_PUSH) || (op == OP_STORE) || (op == OP_LOAD) ||
               (op == OP_JMP) || (op == OP_JZ);
    endfunction

    // Number of stack items an opcode pops.
    function automatic logic [1:0] op_need(input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        if ((op == OP_ADD) || (op == OP_MUL) || (op == OP_DIV) || (op == OP_SUB)) begin
            n = 2'd2;
        end else if ((op == OP_PRINT) || (op == OP_STORE) || (op == OP_JZ)) begin
            n = 2'd1;
        end
        return n;
    endfunction

    // Number of stack items an opcode pushes.
    function automatic logic op_adds(input logic [7:0] op);
        return (op == OP_PUSH) || (op == OP_LOAD) || (op == OP_CALL) ||
               (op == OP_ADD) || (op == OP_MUL) || (op == OP_DIV) || (op == OP_SUB);
    endfunction

endpackage

[rtl/core/stack_bytecode_machine_core.sv]
// Stack bytecode machine: 8-bit opcodes, 32-bit wrapping values, one result per request.
// A load request (mode 0) stores one program byte and goes straight to the result. A step
// request (mode 1) runs one instruction: fetch of the opcode, fetch of the operand byte
// with the top stack read, a second stack read with the variable read, then execute and
// result. ADD, SUB and MUL pass through a write-back state to write the stack; DIV runs a
// one-bit-per-cycle divider before its write-back. A step on a stopped machine goes straight
// to the result. The variable store reads zero until written through per-slot valid bits,
// so no clearing pass follows reset. The next request is taken while a finished result
// still waits on m_ready. Depends on sbm_pkg, sbm_ctrl, sbm_datapath and sbm_div.
module stack_bytecode_machine_core
    import sbm_pkg::*;
#(
    parameter int unsigned PROGRAM_BYTES  = 256,
    parameter int unsigned STACK_DEPTH    = 64,
    parameter int unsigned VARIABLE_SLOTS = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic [7:0]               s_program_byte,
    input  logic                     s_first_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_print_valid,
    output logic signed [DATA_W-1:0] m_print_value,
    output logic [2:0]               m_status
);

    sbm_cmd_t cmd;
    sbm_sts_t sts;

    // The controller only sequences; all machine state and memories live in the datapath.
    sbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sbm_datapath #(
        .PROGRAM_BYTES  (PROGRAM_BYTES),
        .STACK_DEPTH    (STACK_DEPTH),
        .VARIABLE_SLOTS (VARIABLE_SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_valid        (s_valid),
        .s_mode         (s_mode),
        .s_program_byte (s_program_byte),
        .s_first_byte   (s_first_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_print_valid  (m_print_valid),
        .m_print_value  (m_print_value),
        .m_status       (m_status)
    );

endmodule

[rtl/core/sbm_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on sbm_pkg.
module sbm_div
    import sbm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DATA_W-1:0]        dividend,
    input  logic [DATA_W-1:0]        divisor,
    output logic                     done,
    output logic [DATA_W-1:0]        quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   quo_reg, quo_next;
    logic [DATA_W-1:0]   den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
            end else begin
                rem_next = shifted[DATA_W-1:0];
            end
            quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

[rtl/core/sbm_datapath.sv]
// Datapath of the stack machine: program, stack and variable memories, machine registers,
// fault checks, ALU and the result register. Depends on sbm_pkg and sbm_div.
module sbm_datapath
    import sbm_pkg::*;
#(
    parameter int unsigned PROGRAM_BYTES  = 256,
    parameter int unsigned STACK_DEPTH    = 64,
    parameter int unsigned VARIABLE_SLOTS = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sbm_cmd_t                 cmd,
    output sbm_sts_t                 sts,
    input  logic                     s_valid,
    input  logic                     s_mode,
    input  logic [7:0]               s_program_byte,
    input  logic                     s_first_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_print_valid,
    output logic signed [DATA_W-1:0] m_print_value,
    output logic [2:0]               m_status
);

    localparam int unsigned AW  = $clog2(PROGRAM_BYTES);
    localparam int unsigned SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned VW  = (VARIABLE_SLOTS > 1) ? $clog2(VARIABLE_SLOTS) : 1;
    localparam logic [PC_W:0]  PROG_LIM  = (PC_W + 1)'(PROGRAM_BYTES);
    localparam logic [SPW+1:0] DEPTH_LIM = (SPW + 2)'(STACK_DEPTH);
    localparam logic [8:0]     SLOT_LIM  = 9'(VARIABLE_SLOTS);

    logic [7:0]        prog_mem [PROGRAM_BYTES];
    logic [DATA_W-1:0] stk_mem  [STACK_DEPTH];
    logic [DATA_W-1:0] var_mem  [VARIABLE_SLOTS];
    logic [VARIABLE_SLOTS-1:0] var_valid_reg;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [PC_W-1:0]   len_reg, len_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [2:0]        status_reg, status_next;
    logic [7:0]        prog_q, op_reg, arg_reg;
    logic [DATA_W-1:0] stk_q, a_reg, alu_reg, var_q;
    logic              var_vq;
    logic              res_pv_reg, res_pv_next;
    logic [DATA_W-1:0] res_val_reg, res_val_next;
    logic              m_valid_reg;
    logic              m_pv_reg;
    logic [DATA_W-1:0] m_val_reg;
    logic [2:0]        m_status_reg;

    logic [PC_W-1:0]   len_base;
    logic              prog_we;
    logic [PC_W-1:0]   prog_rd;
    logic [SPW-1:0]    stk_rd;
    logic              stk_we;
    logic [SPW-1:0]    stk_wa;
    logic [DATA_W-1:0] stk_wd;
    logic              var_we;
    logic [1:0]        need;
    logic              adds;
    logic              past_arg, under, over, divz;
    logic [2:0]        fault_code;
    logic              arg_in_range;
    logic [DATA_W-1:0] arg_ext;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    // Load handling: a first byte restarts the program before the byte is stored.
    assign len_base = s_first_byte ? '0 : len_reg;
    assign prog_we  = cmd.capture && !s_mode && ({1'b0, len_base} < PROG_LIM);
    assign prog_rd  = cmd.latch_op ? (pc_reg + 9'd1) : pc_reg;

    always_ff @(posedge aclk) begin
        if (prog_we) begin
            prog_mem[len_base[AW-1:0]] <= s_program_byte;
        end
        prog_q <= prog_mem[prog_rd[AW-1:0]];
    end

    // Fault checks in the priority the machine defines.
    assign need         = op_need(op_reg);
    assign adds         = op_adds(op_reg);
    assign past_arg     = op_has_arg(op_reg) && (({1'b0, pc_reg} + 10'd1) >= {1'b0, len_reg});
    assign under        = sp_reg < SPW'(need);
    assign over         = ((SPW + 2)'(sp_reg) + (SPW + 2)'(adds)) > (DEPTH_LIM + (SPW + 2)'(need));
    assign divz         = (op_reg == OP_DIV) && (a_reg == '0);
    assign arg_in_range = {1'b0, arg_reg} < SLOT_LIM;
    assign arg_ext      = DATA_W'(arg_reg);

    always_comb begin
        priority if (past_arg) begin
            fault_code = STAT_PAST;
        end else if (under) begin
            fault_code = STAT_UNDER;
        end else if (over) begin
            fault_code = STAT_OVER;
        end else if (divz) begin
            fault_code = STAT_DIVZ;
        end else begin
            fault_code = STAT_RUN;
        end
    end

    // Stack memory: one read port, one write port.
    assign stk_rd = cmd.latch_op ? (sp_reg - 1'b1) : (sp_reg - SPW'(2));

    always_comb begin
        stk_we = 1'b0;
        stk_wa = sp_reg;
        stk_wd = alu_reg;
        if (cmd.execute && (fault_code == STAT_RUN)) begin
            if ((op_reg == OP_PUSH) || (op_reg == OP_LOAD) || (op_reg == OP_CALL)) begin
                stk_we = 1'b1;
            end
            if (op_reg == OP_PUSH) begin
                stk_wd = arg_ext;
            end else if (op_reg == OP_LOAD) begin
                stk_wd = (arg_in_range && var_vq) ? var_q : '0;
            end else begin
                stk_wd = DATA_W'(pc_reg) + 32'd1;
            end
        end else if (cmd.write_back) begin
            stk_we = 1'b1;
            stk_wa = sp_reg - SPW'(2);
            stk_wd = (op_reg == OP_DIV) ? div_q : alu_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_wa[SW-1:0]] <= stk_wd;
        end
        stk_q <= stk_mem[stk_rd[SW-1:0]];
    end

    // Variable store: entries read as zero until written.
    assign var_we = cmd.execute && (fault_code == STAT_RUN) && (op_reg == OP_STORE) &&
                    arg_in_range;

    always_ff @(posedge aclk) begin
        if (var_we) begin
            var_mem[arg_reg[VW-1:0]] <= a_reg;
        end
        var_q  <= var_mem[prog_q[VW-1:0]];
        var_vq <= var_valid_reg[prog_q[VW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_valid_reg <= '0;
        end else if (var_we) begin
            var_valid_reg[arg_reg[VW-1:0]] <= 1'b1;
        end
    end

    sbm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.execute && (fault_code == STAT_RUN) && (op_reg == OP_DIV)),
        .dividend (stk_q),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Machine registers.
    always_comb begin
        pc_next      = pc_reg;
        len_next     = len_reg;
        sp_next      = sp_reg;
        status_next  = status_reg;
        res_pv_next  = res_pv_reg;
        res_val_next = res_val_reg;
        if (cmd.capture) begin
            res_pv_next  = 1'b0;
            res_val_next = '0;
            if (!s_mode) begin
                if (s_first_byte) begin
                    pc_next     = '0;
                    status_next = STAT_RUN;
                end
                len_next = prog_we ? (len_base + 9'd1) : len_base;
            end else if ((status_reg == STAT_RUN) && (pc_reg >= len_reg)) begin
                status_next = STAT_PAST;
            end
        end else if (cmd.execute) begin
            if (fault_code != STAT_RUN) begin
                status_next = fault_code;
            end else begin
                pc_next = op_has_arg(op_reg) ? (pc_reg + 9'd2) : (pc_reg + 9'd1);
                unique case (op_reg)
                    OP_PUSH, OP_LOAD, OP_CALL: begin
                        sp_next = sp_reg + 1'b1;
                    end
                    OP_PRINT: begin
                        sp_next      = sp_reg - 1'b1;
                        res_pv_next  = 1'b1;
                        res_val_next = a_reg;
                    end
                    OP_STORE: begin
                        sp_next = sp_reg - 1'b1;
                    end
                    OP_HALT: begin
                        status_next = STAT_HALT;
                    end
                    OP_JMP: begin
                        pc_next = PC_W'(arg_reg);
                    end
                    OP_JZ: begin
                        sp_next = sp_reg - 1'b1;
                        if (a_reg == '0) begin
                            pc_next = PC_W'(arg_reg);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (cmd.write_back) begin
            sp_next = sp_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= '0;
            len_reg    <= '0;
            sp_reg     <= '0;
            status_reg <= STAT_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg     <= pc_next;
            len_reg    <= len_next;
            sp_reg     <= sp_next;
            status_reg <= status_next;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        res_pv_reg  <= res_pv_next;
        res_val_reg <= res_val_next;
        if (cmd.latch_op) begin
            op_reg <= prog_q;
        end
        if (cmd.latch_arg) begin
            arg_reg <= prog_q;
            a_reg   <= stk_q;
        end
        if (cmd.execute) begin
            unique case (op_reg)
                OP_ADD:  alu_reg <= stk_q + a_reg;
                OP_SUB:  alu_reg <= stk_q - a_reg;
                default: alu_reg <= stk_q * a_reg;
            endcase
        end
        if (cmd.finish) begin
            m_pv_reg     <= res_pv_reg;
            m_val_reg    <= res_val_reg;
            m_status_reg <= status_reg;
        end
    end

    assign sts.start_exec = s_valid && s_mode && (status_reg == STAT_RUN) && (pc_reg < len_reg);
    assign sts.fault      = fault_code != STAT_RUN;
    assign sts.arith      = (op_reg == OP_ADD) || (op_reg == OP_SUB) ||
                            (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign sts.is_div     = op_reg == OP_DIV;
    assign sts.div_done   = div_done;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_print_valid = m_pv_reg;
    assign m_print_value = m_val_reg;
    assign m_status      = m_status_reg;

endmodule

[rtl/core/sbm_ctrl.sv]
// Sequencer of the stack machine: walks each step request that can run through fetch, execute and result.
// Load requests and steps that cannot run go straight to the result. Depends on sbm_pkg.
module sbm_ctrl
    import sbm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sbm_sts_t sts,
    output sbm_cmd_t cmd
);

    sbm_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.start_exec ? ST_OP : ST_DONE;
                end
            end
            ST_OP:   state_next = ST_ARG;
            ST_ARG:  state_next = ST_EXEC;
            ST_EXEC: begin
                priority if (sts.fault || !sts.arith) begin
                    state_next = ST_DONE;
                end else if (sts.is_div) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB:   state_next = ST_DONE;
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_OP:   cmd.latch_op   = 1'b1;
            ST_ARG:  cmd.latch_arg  = 1'b1;
            ST_EXEC: cmd.execute    = 1'b1;
            ST_WB:   cmd.write_back = 1'b1;
            ST_DONE: cmd.finish     = sts.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/sbm_checker.sv]
// Port-level checks for the stack machine core, attached by the bind at the end.
// Depends on sbm_pkg and stack_bytecode_machine_core.
module sbm_checker
    import sbm_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_print_valid,
    input logic signed [DATA_W-1:0] m_print_value,
    input logic [2:0]               m_status
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_print_value) && $stable(m_status)))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= STAT_PAST))
        else $error("status code out of range");

    // PRINT only executes on a running machine and leaves it running.
    a_print_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_print_valid) |-> (m_status == STAT_RUN))
        else $error("print reported with a stopped machine");

    a_print_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_print_valid) |-> (m_print_value == '0))
        else $error("print value not zero without print");

endmodule

bind stack_bytecode_machine_core sbm_checker u_sbm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_print_valid (m_print_valid),
    .m_print_value (m_print_value),
    .m_status      (m_status)
);
